>>> rtl/isfd_pkg.sv
// Shared constants and types for the IMU serial frame deframer.
package isfd_pkg;

  localparam int FRAME_BYTES = 27;
  localparam int BODY_FIRST  = 2;
  localparam int BODY_LAST   = 24;
  localparam int BODY_BYTES  = BODY_LAST - BODY_FIRST + 1;
  localparam int SUM_END     = 25;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [7:0] SYNC_FIRST  = 8'h5a;
  localparam logic [7:0] SYNC_SECOND = 8'ha5;
  localparam logic [7:0] TYPE_IMU    = 8'h01;
  localparam logic [7:0] IMU_LEN     = 8'd24;
  localparam logic [7:0] CAP_RESET   = 8'd200;

  localparam logic [1:0] STATUS_GOOD       = 2'd0;
  localparam logic [1:0] STATUS_CHECKSUM   = 2'd1;
  localparam logic [1:0] STATUS_WRONG_TYPE = 2'd2;
  localparam logic [1:0] STATUS_BAD_LENGTH = 2'd3;

  // One finished frame: status and frame bytes two to twenty-four.
  typedef struct packed {
    logic [1:0]                 status;
    logic [BODY_BYTES-1:0][7:0] body;
  } frame_rec_t;

endpackage

>>> rtl/isfd_front.sv
// Byte parser: sync hunt, length handling, frame capture and status check.
module isfd_front import isfd_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] cfg_length_cap,
  input  logic       in_push,
  output logic       in_full,
  input  logic [7:0] in_rx_byte,
  input  logic       q_full,
  output logic       q_push,
  output frame_rec_t q_rec
);

  typedef enum logic [2:0] {
    PH_HUNT1,
    PH_HUNT2,
    PH_LEN,
    PH_BODY,
    PH_TAIL
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [7:0]  idx_r, idx_nxt;
  logic [7:0]  rem_r, rem_nxt;
  logic [15:0] sum_r, sum_nxt;
  logic [7:0]  cap_r;
  logic [7:0]  bytes_r [FRAME_BYTES];

  logic        accept;
  logic        finishing;
  logic        store_en;
  logic [4:0]  store_idx;
  logic [7:0]  capped;
  logic [7:0]  rem_dec;
  logic [1:0]  status;

  assign cfg_ready = 1'b1;
  assign finishing = (phase_r == PH_TAIL) && (rem_r == 8'd0);
  // Stall only the byte that closes a frame when the queue has no room.
  assign in_full   = finishing && q_full;
  assign accept    = in_push && !in_full;
  assign q_push    = accept && finishing;

  assign capped  = (in_rx_byte < cap_r) ? in_rx_byte : cap_r;
  assign rem_dec = (rem_r != 8'd0) ? rem_r - 8'd1 : 8'd0;

  always_comb begin
    store_en  = 1'b0;
    store_idx = 5'd0;
    if (accept) begin
      if (phase_r == PH_LEN) begin
        store_en = 1'b1;
      end else if ((phase_r == PH_BODY || phase_r == PH_TAIL) &&
                   idx_r < 8'(FRAME_BYTES)) begin
        store_en  = 1'b1;
        store_idx = idx_r[4:0];
      end
    end
  end

  always_comb begin
    phase_nxt = phase_r;
    idx_nxt   = idx_r;
    rem_nxt   = rem_r;
    sum_nxt   = sum_r;
    case (phase_r)
      PH_HUNT2: begin
        phase_nxt = (in_rx_byte == SYNC_SECOND) ? PH_LEN : PH_HUNT1;
      end
      PH_LEN: begin
        sum_nxt = {8'd0, in_rx_byte};
        idx_nxt = 8'd1;
        if (capped == 8'd0) begin
          phase_nxt = PH_TAIL;
          rem_nxt   = 8'd1;
        end else begin
          phase_nxt = PH_BODY;
          rem_nxt   = capped;
        end
      end
      PH_BODY, PH_TAIL: begin
        if (idx_r < 8'(SUM_END)) begin
          sum_nxt = sum_r + {8'd0, in_rx_byte};
        end
        if (idx_r != 8'hff) begin
          idx_nxt = idx_r + 8'd1;
        end
        if (phase_r == PH_BODY) begin
          if (rem_dec == 8'd0) begin
            phase_nxt = PH_TAIL;
            rem_nxt   = 8'd1;
          end else begin
            rem_nxt = rem_dec;
          end
        end else if (rem_r == 8'd0) begin
          phase_nxt = PH_HUNT1;
        end else begin
          rem_nxt = rem_dec;
        end
      end
      default: begin
        phase_nxt = (in_rx_byte == SYNC_FIRST) ? PH_HUNT2 : PH_HUNT1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HUNT1;
      idx_r   <= 8'd0;
      rem_r   <= 8'd0;
      sum_r   <= 16'd0;
      cap_r   <= CAP_RESET;
    end else begin
      if (accept) begin
        phase_r <= phase_nxt;
        idx_r   <= idx_nxt;
        rem_r   <= rem_nxt;
        sum_r   <= sum_nxt;
      end
      if (cfg_valid) begin
        cap_r <= cfg_length_cap;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (store_en) begin
      bytes_r[store_idx] <= in_rx_byte;
    end
  end

  // The closing byte is the checksum high byte on a well-formed frame.
  always_comb begin
    if (bytes_r[1] != TYPE_IMU) begin
      status = STATUS_WRONG_TYPE;
    end else if (bytes_r[0] != IMU_LEN || idx_r != 8'(FRAME_BYTES - 1)) begin
      status = STATUS_BAD_LENGTH;
    end else if (sum_r == {in_rx_byte, bytes_r[SUM_END]}) begin
      status = STATUS_GOOD;
    end else begin
      status = STATUS_CHECKSUM;
    end
  end

  always_comb begin
    q_rec.status = status;
    for (int k = 0; k < BODY_BYTES; k++) begin
      q_rec.body[k] = bytes_r[BODY_FIRST + k];
    end
  end

endmodule

>>> rtl/isfd_queue.sv
// Short record queue between the parser and the result stage.
module isfd_queue import isfd_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  frame_rec_t push_rec,
  output logic       full,
  input  logic       pop,
  output logic       empty,
  output frame_rec_t pop_rec
);

  localparam int PW = $clog2(QUEUE_DEPTH);

  frame_rec_t    mem_r [QUEUE_DEPTH];
  logic [PW-1:0] wr_r, wr_nxt;
  logic [PW-1:0] rd_r, rd_nxt;
  logic [PW:0]   cnt_r, cnt_nxt;
  logic          do_push;
  logic          do_pop;

  assign full    = (cnt_r == (PW + 1)'(QUEUE_DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign pop_rec = mem_r[rd_r];

  always_comb begin
    wr_nxt  = wr_r;
    rd_nxt  = rd_r;
    cnt_nxt = cnt_r;
    if (do_push) begin
      wr_nxt = (wr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_r + 1'b1;
    end
    if (do_pop) begin
      rd_nxt = (rd_r == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_r + 1'b1;
    end
    case ({do_push, do_pop})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_r] <= push_rec;
    end
  end

endmodule

>>> rtl/isfd_back.sv
// Result stage: unpack fields, blank rejected frames, hold the result.
module isfd_back import isfd_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_empty,
  input  frame_rec_t         q_rec,
  output logic               q_pop,
  output logic               out_empty,
  input  logic               out_pop,
  output logic [1:0]         out_status,
  output logic [7:0]         out_frame_count,
  output logic [31:0]        out_timestamp_us,
  output logic [15:0]        out_acc_range,
  output logic signed [15:0] out_acc_x,
  output logic signed [15:0] out_acc_y,
  output logic signed [15:0] out_acc_z,
  output logic [15:0]        out_gyro_range,
  output logic signed [15:0] out_gyro_x,
  output logic signed [15:0] out_gyro_y,
  output logic signed [15:0] out_gyro_z,
  output logic signed [15:0] out_temperature
);

  logic                       valid_r;
  logic                       load;
  logic                       blank;
  logic [BODY_BYTES-1:0][7:0] b;

  assign load      = !q_empty && (!valid_r || out_pop);
  assign q_pop     = load;
  assign out_empty = !valid_r;

  assign blank = (q_rec.status == STATUS_WRONG_TYPE) ||
                 (q_rec.status == STATUS_BAD_LENGTH);
  assign b     = blank ? '0 : q_rec.body;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (out_pop) begin
      valid_r <= 1'b0;
    end
  end

  // Body entry k carries frame byte k + 2; words are little-endian.
  always_ff @(posedge clk) begin
    if (load) begin
      out_status       <= q_rec.status;
      out_frame_count  <= b[0];
      out_timestamp_us <= {b[4], b[3], b[2], b[1]};
      out_acc_range    <= {b[6], b[5]};
      out_acc_x        <= {b[8], b[7]};
      out_acc_y        <= {b[10], b[9]};
      out_acc_z        <= {b[12], b[11]};
      out_gyro_range   <= {b[14], b[13]};
      out_gyro_x       <= {b[16], b[15]};
      out_gyro_y       <= {b[18], b[17]};
      out_gyro_z       <= {b[20], b[19]};
      out_temperature  <= {b[22], b[21]};
    end
  end

endmodule

>>> rtl/imu_serial_frame_deframer_top.sv
// Top level of the IMU serial frame deframer.
//
// Takes one received byte per request on the in_ queue side, hunts for the
// sync pair 0x5A 0xA5, reads the length byte and then consumes the length
// (limited by cfg_length_cap) plus two more bytes. On the last byte of a
// frame one result is queued: status 0 good, 1 checksum error (fields still
// unpacked), 2 wrong type or 3 bad length (fields zero). A byte is accepted
// every cycle; the only stall is on the byte that closes a frame while the
// two-entry record queue is full. When nothing is waiting ahead of it, a
// result moves from the edge that accepts its closing byte into the record
// queue, then into the output register that drives the out_ ports.
// The length cap is written through the cfg_ channel, which is always ready;
// write it only while no frame is in progress, as it is sampled at the length
// byte.
module imu_serial_frame_deframer_top import isfd_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [7:0]         cfg_length_cap,
  input  logic               in_push,
  output logic               in_full,
  input  logic [7:0]         in_rx_byte,
  output logic               out_empty,
  input  logic               out_pop,
  output logic [1:0]         out_status,
  output logic [7:0]         out_frame_count,
  output logic [31:0]        out_timestamp_us,
  output logic [15:0]        out_acc_range,
  output logic signed [15:0] out_acc_x,
  output logic signed [15:0] out_acc_y,
  output logic signed [15:0] out_acc_z,
  output logic [15:0]        out_gyro_range,
  output logic signed [15:0] out_gyro_x,
  output logic signed [15:0] out_gyro_y,
  output logic signed [15:0] out_gyro_z,
  output logic signed [15:0] out_temperature
);

  // Parser to queue.
  logic       q_push;
  logic       q_full;
  frame_rec_t q_in_rec;

  // Queue to result stage.
  logic       q_pop;
  logic       q_empty;
  frame_rec_t q_out_rec;

  // Parse bytes and classify each closed frame.
  isfd_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_length_cap (cfg_length_cap),
    .in_push        (in_push),
    .in_full        (in_full),
    .in_rx_byte     (in_rx_byte),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_rec          (q_in_rec)
  );

  // Hold finished frames so the parser keeps running while results wait.
  isfd_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_rec (q_in_rec),
    .full     (q_full),
    .pop      (q_pop),
    .empty    (q_empty),
    .pop_rec  (q_out_rec)
  );

  // Unpack the oldest frame into the output register.
  isfd_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_empty          (q_empty),
    .q_rec            (q_out_rec),
    .q_pop            (q_pop),
    .out_empty        (out_empty),
    .out_pop          (out_pop),
    .out_status       (out_status),
    .out_frame_count  (out_frame_count),
    .out_timestamp_us (out_timestamp_us),
    .out_acc_range    (out_acc_range),
    .out_acc_x        (out_acc_x),
    .out_acc_y        (out_acc_y),
    .out_acc_z        (out_acc_z),
    .out_gyro_range   (out_gyro_range),
    .out_gyro_x       (out_gyro_x),
    .out_gyro_y       (out_gyro_y),
    .out_gyro_z       (out_gyro_z),
    .out_temperature  (out_temperature)
  );

endmodule

>>> dv/tb_top.sv
// Self-checking testbench for the IMU serial frame deframer.
module tb_top;
  import isfd_pkg::*;

  // Hunting and framing phases of the byte stream, as tracked by the predictor.
  typedef enum logic [2:0] {
    SEEK_FIRST, SEEK_SECOND, TAKE_LEN, TAKE_BODY, TAKE_TAIL
  } link_phase_t;

  // How the body bytes of a generated frame are filled.
  typedef enum logic [1:0] {FILL_CONST, FILL_COUNT, FILL_RANDOM} fill_mode_t;

  typedef struct {
    logic [1:0]         status;
    logic [7:0]         frame_count;
    logic [31:0]        timestamp_us;
    logic [15:0]        acc_range;
    logic signed [15:0] acc_x;
    logic signed [15:0] acc_y;
    logic signed [15:0] acc_z;
    logic [15:0]        gyro_range;
    logic signed [15:0] gyro_x;
    logic signed [15:0] gyro_y;
    logic signed [15:0] gyro_z;
    logic signed [15:0] temperature;
  } imu_record_t;

  typedef logic [31:0] field_set_t [12];

  // One directed frame: cap in force, optional broken sync ahead of it, header,
  // body fill and, where it is plain to see, the record it must yield.
  typedef struct {
    logic [7:0] cap;
    bit         break_sync;
    logic [7:0] len;
    logic [7:0] ftype;
    fill_mode_t mode;
    logic [7:0] fill;
    bit         bad_sum;
    bit         typed;
    logic [1:0] status;
  } frame_row_t;

  localparam int LATENCY      = 2;
  localparam int IDLE_LIMIT   = 2000;
  localparam int REPORT_LIMIT = 10;
  localparam int PHASE_BYTES  = 40;
  localparam int NUM_PHASES   = 7;

  logic               clk            = 1'b0;
  logic               rst_n          = 1'b0;
  logic               cfg_valid      = 1'b0;
  logic               cfg_ready;
  logic [7:0]         cfg_length_cap = CAP_RESET;
  logic               in_push        = 1'b0;
  logic               in_full;
  logic [7:0]         in_rx_byte     = 8'h00;
  logic               out_empty;
  logic               out_pop        = 1'b0;
  logic [1:0]         out_status;
  logic [7:0]         out_frame_count;
  logic [31:0]        out_timestamp_us;
  logic [15:0]        out_acc_range;
  logic signed [15:0] out_acc_x;
  logic signed [15:0] out_acc_y;
  logic signed [15:0] out_acc_z;
  logic [15:0]        out_gyro_range;
  logic signed [15:0] out_gyro_x;
  logic signed [15:0] out_gyro_y;
  logic signed [15:0] out_gyro_z;
  logic signed [15:0] out_temperature;

  imu_serial_frame_deframer_top dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_length_cap   (cfg_length_cap),
    .in_push          (in_push),
    .in_full          (in_full),
    .in_rx_byte       (in_rx_byte),
    .out_empty        (out_empty),
    .out_pop          (out_pop),
    .out_status       (out_status),
    .out_frame_count  (out_frame_count),
    .out_timestamp_us (out_timestamp_us),
    .out_acc_range    (out_acc_range),
    .out_acc_x        (out_acc_x),
    .out_acc_y        (out_acc_y),
    .out_acc_z        (out_acc_z),
    .out_gyro_range   (out_gyro_range),
    .out_gyro_x       (out_gyro_x),
    .out_gyro_y       (out_gyro_y),
    .out_gyro_z       (out_gyro_z),
    .out_temperature  (out_temperature)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Predictor state: a private copy of the deframer and its length cap.
  link_phase_t link_phase = SEEK_FIRST;
  logic [7:0]  frame_buf [FRAME_BYTES];
  logic [7:0]  write_pos  = 8'd0;
  logic [7:0]  left       = 8'd0;
  logic [15:0] run_sum    = 16'd0;
  logic [7:0]  cap_now    = CAP_RESET;

  imu_record_t pending_records [$];
  imu_record_t typed_rec;
  bit          typed_on      = 1'b0;
  bit          send_calm     = 1'b0;
  int          bytes_sent    = 0;
  int          mismatch_count = 0;
  int          idle_cycles   = 0;
  int          pop_hold      = 0;
  bit          pop_calm      = 1'b0;

  string field_names [12] = '{"status", "frame_count", "timestamp_us", "acc_range",
                              "acc_x", "acc_y", "acc_z", "gyro_range", "gyro_x",
                              "gyro_y", "gyro_z", "temperature"};

  // Directed frames: the extremes of every field, each status, broken sync,
  // long and empty frames, and the cap at its extremes and around 24.
  frame_row_t directed_rows [21] = '{
    '{CAP_RESET, 1'b0, IMU_LEN, TYPE_IMU, FILL_CONST,  8'h00, 1'b0, 1'b1, STATUS_GOOD},
    '{CAP_RESET, 1'b0, IMU_LEN, TYPE_IMU, FILL_CONST,  8'hff, 1'b0, 1'b1, STATUS_GOOD},
    '{CAP_RESET, 1'b0, IMU_LEN, TYPE_IMU, FILL_COUNT,  8'h00, 1'b0, 1'b0, STATUS_GOOD},
    '{CAP_RESET, 1'b0, IMU_LEN, TYPE_IMU, FILL_CONST,  8'h80, 1'b1, 1'b1, STATUS_CHECKSUM},
    '{CAP_RESET, 1'b1, IMU_LEN, TYPE_IMU, FILL_CONST,  8'h7f, 1'b0, 1'b1, STATUS_GOOD},
    '{CAP_RESET, 1'b0, IMU_LEN, 8'h02,    FILL_RANDOM, 8'h00, 1'b0, 1'b1, STATUS_WRONG_TYPE},
    '{CAP_RESET, 1'b0, IMU_LEN, 8'h00,    FILL_RANDOM, 8'h00, 1'b0, 1'b1, STATUS_WRONG_TYPE},
    '{CAP_RESET, 1'b0, IMU_LEN, 8'hff,    FILL_RANDOM, 8'h00, 1'b0, 1'b1, STATUS_WRONG_TYPE},
    '{CAP_RESET, 1'b0, 8'd23,   TYPE_IMU, FILL_RANDOM, 8'h00, 1'b0, 1'b1, STATUS_BAD_LENGTH},
    '{CAP_RESET, 1'b0, 8'd25,   TYPE_IMU, FILL_RANDOM, 8'h00, 1'b0, 1'b1, STATUS_BAD_LENGTH},
    '{CAP_RESET, 1'b0, 8'd0,    TYPE_IMU, FILL_RANDOM, 8'h00, 1'b0, 1'b1, STATUS_BAD_LENGTH},
    '{CAP_RESET, 1'b0, 8'hff,   TYPE_IMU, FILL_RANDOM, 8'h00, 1'b0, 1'b1, STATUS_BAD_LENGTH},
    '{8'hff,     1'b0, 8'hff,   TYPE_IMU, FILL_RANDOM, 8'h00, 1'b0, 1'b1, STATUS_BAD_LENGTH},
    '{8'hff,     1'b0, IMU_LEN, TYPE_IMU, FILL_RANDOM, 8'h00, 1'b0, 1'b0, STATUS_GOOD},
    '{8'd0,      1'b0, IMU_LEN, TYPE_IMU, FILL_RANDOM, 8'h00, 1'b0, 1'b1, STATUS_BAD_LENGTH},
    '{8'd0,      1'b0, IMU_LEN, 8'h05,    FILL_RANDOM, 8'h00, 1'b0, 1'b1, STATUS_WRONG_TYPE},
    '{8'd23,     1'b0, IMU_LEN, TYPE_IMU, FILL_RANDOM, 8'h00, 1'b0, 1'b1, STATUS_BAD_LENGTH},
    '{IMU_LEN,   1'b0, IMU_LEN, TYPE_IMU, FILL_RANDOM, 8'h00, 1'b0, 1'b0, STATUS_GOOD},
    '{IMU_LEN,   1'b0, 8'd200,  TYPE_IMU, FILL_RANDOM, 8'h00, 1'b0, 1'b1, STATUS_BAD_LENGTH},
    '{8'd25,     1'b0, IMU_LEN, TYPE_IMU, FILL_RANDOM, 8'h00, 1'b1, 1'b0, STATUS_GOOD},
    '{8'd1,      1'b0, 8'd50,   TYPE_IMU, FILL_RANDOM, 8'h00, 1'b0, 1'b1, STATUS_BAD_LENGTH}
  };

  // Caps for the random phases; slot five is drawn at random.
  logic [7:0] phase_caps [NUM_PHASES] = '{CAP_RESET, IMU_LEN, 8'hff, 8'd23, 8'd0,
                                          8'd0, CAP_RESET};

  // Idle length for either side: mostly none or short, now and then long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [15:0] le16(input int pos);
    return {frame_buf[pos+1], frame_buf[pos]};
  endfunction

  // Store a frame byte; the write position saturates and the sum stops at
  // the checksum word.
  function automatic void store_byte(input logic [7:0] b);
    if (write_pos < FRAME_BYTES) frame_buf[write_pos] = b;
    if (write_pos < SUM_END) run_sum = run_sum + {8'h00, b};
    if (write_pos != 8'hff) write_pos = write_pos + 8'd1;
  endfunction

  // Advance the predictor by one accepted byte; return 1 when a record closes.
  function automatic bit step_deframer(input logic [7:0] b, output imu_record_t rec);
    logic [7:0] capped;
    rec = '{default: '0};
    step_deframer = 1'b0;
    case (link_phase)
      SEEK_SECOND: begin
        // anything but the second sync byte is dropped, never taken as a first
        link_phase = (b == SYNC_SECOND) ? TAKE_LEN : SEEK_FIRST;
      end
      TAKE_LEN: begin
        frame_buf[0] = b;
        run_sum      = {8'h00, b};
        write_pos    = 8'd1;
        capped       = (b < cap_now) ? b : cap_now;
        if (capped == 8'd0) begin
          link_phase = TAKE_TAIL;
          left       = 8'd1;
        end else begin
          link_phase = TAKE_BODY;
          left       = capped;
        end
      end
      TAKE_BODY: begin
        store_byte(b);
        if (left != 8'd0) left = left - 8'd1;
        if (left == 8'd0) begin
          link_phase = TAKE_TAIL;
          left       = 8'd1;
        end
      end
      TAKE_TAIL: begin
        store_byte(b);
        if (left == 8'd0) begin
          if (frame_buf[1] != TYPE_IMU) begin
            rec.status = STATUS_WRONG_TYPE;
          end else if (frame_buf[0] != IMU_LEN || write_pos != FRAME_BYTES) begin
            rec.status = STATUS_BAD_LENGTH;
          end else begin
            rec.status       = (run_sum == le16(25)) ? STATUS_GOOD : STATUS_CHECKSUM;
            rec.frame_count  = frame_buf[2];
            rec.timestamp_us = {le16(5), le16(3)};
            rec.acc_range    = le16(7);
            rec.acc_x        = le16(9);
            rec.acc_y        = le16(11);
            rec.acc_z        = le16(13);
            rec.gyro_range   = le16(15);
            rec.gyro_x       = le16(17);
            rec.gyro_y       = le16(19);
            rec.gyro_z       = le16(21);
            rec.temperature  = le16(23);
          end
          link_phase    = SEEK_FIRST;
          step_deframer = 1'b1;
        end else begin
          left = left - 8'd1;
        end
      end
      default: begin
        link_phase = (b == SYNC_FIRST) ? SEEK_SECOND : SEEK_FIRST;
      end
    endcase
  endfunction

  function automatic field_set_t flatten(input imu_record_t r);
    field_set_t f;
    f[0]  = {30'h0, r.status};
    f[1]  = {24'h0, r.frame_count};
    f[2]  = r.timestamp_us;
    f[3]  = {16'h0, r.acc_range};
    f[4]  = {16'h0, r.acc_x};
    f[5]  = {16'h0, r.acc_y};
    f[6]  = {16'h0, r.acc_z};
    f[7]  = {16'h0, r.gyro_range};
    f[8]  = {16'h0, r.gyro_x};
    f[9]  = {16'h0, r.gyro_y};
    f[10] = {16'h0, r.gyro_z};
    f[11] = {16'h0, r.temperature};
    return f;
  endfunction

  function automatic void note_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= REPORT_LIMIT) $display("MISMATCH at %0t: %s", $realtime, what);
  endfunction

  // Offer one byte, hold it until the request is taken, then record what the
  // predictor expects before any idle gap so the result can never overtake it.
  task automatic push_byte(input logic [7:0] b);
    imu_record_t rec;
    int          gap;
    in_push    <= 1'b1;
    in_rx_byte <= b;
    do @(posedge clk); while (in_full);
    if (step_deframer(b, rec)) begin
      pending_records.insert(pending_records.size(), typed_on ? typed_rec : rec);
      typed_on = 1'b0;
    end
    bytes_sent++;
    gap = send_calm ? 0 : pick_gap();
    if (gap > 0) begin
      in_push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Sync pair, length, type, body and checksum word; the byte count follows
  // the cap in force so that a frame closes on its own last byte.
  task automatic send_frame(input logic [7:0] len, input logic [7:0] ftype,
                            input fill_mode_t mode, input logic [7:0] fill,
                            input bit bad_sum);
    logic [7:0]  fb [258];
    logic [7:0]  capped;
    logic [15:0] sum;
    int          n;
    capped = (len < cap_now) ? len : cap_now;
    n      = (capped == 8'd0) ? 2 : int'(capped) + 2;
    for (int i = 0; i < 258; i++) begin
      case (mode)
        FILL_CONST: fb[i] = fill;
        FILL_COUNT: fb[i] = 8'(fill + i);
        default:    fb[i] = 8'($urandom);
      endcase
    end
    fb[0] = len;
    fb[1] = ftype;
    sum   = 16'd0;
    for (int i = 0; i < SUM_END; i++) sum = sum + {8'h00, fb[i]};
    if (bad_sum) sum = sum + 16'($urandom_range(1, 65535));
    fb[25] = sum[7:0];
    fb[26] = sum[15:8];
    push_byte(SYNC_FIRST);
    push_byte(SYNC_SECOND);
    for (int i = 0; i <= n; i++) push_byte(fb[i]);
  endtask

  // Bring the stream back to hunting, drain every result, let the pipeline
  // settle, then write the cap in one request.
  task automatic program_length_cap(input logic [7:0] value);
    send_calm = 1'b0;
    while (link_phase != SEEK_FIRST) push_byte(8'h00);
    in_push <= 1'b0;
    while (pending_records.size() != 0) @(posedge clk);
    repeat (LATENCY + 2) @(posedge clk);
    cfg_valid      <= 1'b1;
    cfg_length_cap <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    cap_now = value;
  endtask

  // Result side: check each popped record against the oldest expectation,
  // stall the pop at random, and watch for a run with nothing moving.
  always @(posedge clk) begin : check_results
    imu_record_t got;
    imu_record_t want;
    field_set_t  got_f;
    field_set_t  want_f;
    if (rst_n) begin
      if (out_pop && !out_empty) begin
        got.status       = out_status;
        got.frame_count  = out_frame_count;
        got.timestamp_us = out_timestamp_us;
        got.acc_range    = out_acc_range;
        got.acc_x        = out_acc_x;
        got.acc_y        = out_acc_y;
        got.acc_z        = out_acc_z;
        got.gyro_range   = out_gyro_range;
        got.gyro_x       = out_gyro_x;
        got.gyro_y       = out_gyro_y;
        got.gyro_z       = out_gyro_z;
        got.temperature  = out_temperature;
        if (pending_records.size() == 0) begin
          note_mismatch($sformatf("record with status %0d and none awaited", got.status));
        end else begin
          want   = pending_records.pop_front();
          got_f  = flatten(got);
          want_f = flatten(want);
          for (int k = 0; k < 12; k++) begin
            if (got_f[k] !== want_f[k])
              note_mismatch($sformatf("%s expected %0h actual %0h",
                                      field_names[k], want_f[k], got_f[k]));
          end
        end
      end
      // flip between calm stretches and stalling stretches now and then
      if ($urandom_range(0, 499) == 0) pop_calm = !pop_calm;
      if (pop_hold > 0) begin
        out_pop <= 1'b0;
        pop_hold--;
      end else begin
        out_pop <= 1'b1;
        if (!pop_calm && $urandom_range(0, 3) == 0) pop_hold = pick_gap();
      end
    end
    if ((in_push && !in_full) || (out_pop && !out_empty) || (cfg_valid && cfg_ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin : stimulus
    frame_row_t row;
    int         phase_start;
    int         pick;
    logic [7:0] ftype;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Directed frames; typed rows carry their record, the rest use the predictor.
    for (int r = 0; r < 21; r++) begin
      row = directed_rows[r];
      if (row.cap != cap_now) program_length_cap(row.cap);
      send_calm = ($urandom_range(0, 2) == 0);
      if (row.break_sync) begin
        push_byte(SYNC_FIRST);
        push_byte(SYNC_FIRST);
        push_byte(SYNC_SECOND);
      end
      if (row.typed) begin
        typed_rec        = '{default: '0};
        typed_rec.status = row.status;
        if (row.status == STATUS_GOOD || row.status == STATUS_CHECKSUM) begin
          typed_rec.frame_count  = row.fill;
          typed_rec.timestamp_us = {4{row.fill}};
          typed_rec.acc_range    = {2{row.fill}};
          typed_rec.acc_x        = {2{row.fill}};
          typed_rec.acc_y        = {2{row.fill}};
          typed_rec.acc_z        = {2{row.fill}};
          typed_rec.gyro_range   = {2{row.fill}};
          typed_rec.gyro_x       = {2{row.fill}};
          typed_rec.gyro_y       = {2{row.fill}};
          typed_rec.gyro_z       = {2{row.fill}};
          typed_rec.temperature  = {2{row.fill}};
        end
        typed_on = 1'b1;
      end
      send_frame(row.len, row.ftype, row.mode, row.fill, row.bad_sum);
    end

    // Random phases, one per cap setting: mostly well-formed frames with
    // random content, the rest wrong type, bad length, noise and broken sync.
    for (int p = 0; p < NUM_PHASES; p++) begin
      program_length_cap(p == 5 ? 8'($urandom) : phase_caps[p]);
      phase_start = bytes_sent;
      while (bytes_sent - phase_start < PHASE_BYTES) begin
        send_calm = ($urandom_range(0, 3) == 0);
        pick      = $urandom_range(0, 99);
        if (pick < 60) begin
          send_frame(IMU_LEN, TYPE_IMU, FILL_RANDOM, 8'h00, $urandom_range(0, 9) == 0);
        end else if (pick < 70) begin
          ftype = 8'($urandom);
          if (ftype == TYPE_IMU) ftype = 8'h00;
          send_frame($urandom_range(0, 1) ? IMU_LEN : 8'($urandom_range(0, 40)),
                     ftype, FILL_RANDOM, 8'h00, 1'b0);
        end else if (pick < 82) begin
          send_frame($urandom_range(0, 9) == 0 ? 8'($urandom) : 8'($urandom_range(0, 40)),
                     TYPE_IMU, FILL_RANDOM, 8'h00, 1'b0);
        end else if (pick < 92) begin
          repeat ($urandom_range(1, 6))
            push_byte($urandom_range(0, 3) == 0 ? SYNC_FIRST : 8'($urandom));
        end else begin
          push_byte(SYNC_FIRST);
          ftype = 8'($urandom);
          push_byte(ftype == SYNC_SECOND ? SYNC_FIRST : ftype);
        end
      end
    end

    // Drain: stop requesting, wait for every record, then let the pipeline settle.
    in_push <= 1'b0;
    while (pending_records.size() != 0) @(posedge clk);
    repeat (LATENCY + 2) @(posedge clk);
    if (mismatch_count == 0 && pending_records.size() == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
